### hdl/bde_pkg.sv
// ----------------------------------------------------------------------------
// bde_pkg - braking distance estimator shared definitions
// widths, fixed coefficient sets, scale and offset constants
// ----------------------------------------------------------------------------
package bde_pkg;

  // parameter defaults
  localparam int unsigned TermCountDefault = 16;
  localparam int unsigned FracBitsDefault  = 16;
  localparam int unsigned MaxTerms         = 32;

  // item and register widths
  localparam int unsigned VelW   = 24;
  localparam int unsigned DecW   = 23;
  localparam int unsigned V2W    = 2 * VelW;
  localparam int unsigned BrkW   = 32;
  localparam int unsigned EmgW   = 31;
  localparam int unsigned DataOW = 64;

  localparam logic [DecW-1:0] DecReset = 23'd642908;

  // shared multiplier operand width
  localparam int unsigned MulW = 32;

  // horner accumulator magnitude, clamp at 2^61 - 1
  localparam int unsigned AccMagW = 61;

  // slow set below 50.0 m/s, q16.16
  localparam longint SlowLimitQ16 = 64'sd3276800;

  // offsets (q16.16) and scales (units of 1e-4)
  localparam longint OffSlowQ16  = (64'sd300079 * 64'sd65536 + 64'sd5000) / 64'sd10000;
  localparam longint OffFastQ16  = (64'sd414985 * 64'sd65536 + 64'sd5000) / 64'sd10000;
  localparam longint ScaleSlowE4 = 64'sd172325;
  localparam longint ScaleFastE4 = 64'sd235436;

  // coefficients in units of 1e-4, constant term first
  localparam int SlowCoefE4 [MaxTerms] = '{
    1363132, 1589403, 636093, -354894, -1492755, 1526967, 5025464, -2184689,
    -7795340, 957285, 6211013, 504598, -2450990, -545000, 380642, 123548,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
  localparam int FastCoefE4 [MaxTerms] = '{
    2586000, 2992000, 1152000, -1047000, -2609000, 4885000, 9408000, -8085000,
    -15519000, 5517000, 13157000, -614000, -5514000, -845000, 907000, 262000,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  // round(e4 * 2^frac / 10000), ties away from zero
  function automatic longint coef_fixed(input int e4, input int unsigned frac);
    longint m;
    m = (e4 < 0) ? -longint'(e4) : longint'(e4);
    m = ((m << frac) + 64'sd5000) / 64'sd10000;
    return (e4 < 0) ? -m : m;
  endfunction

endpackage

### hdl/bde_mul.sv
// ----------------------------------------------------------------------------
// bde_mul - shared unsigned multiplier
// one 32x32 product per cycle, result registered
// ----------------------------------------------------------------------------
module bde_mul (
  input  logic                            clk_i,
  input  logic [bde_pkg::MulW-1:0]        a_i,
  input  logic [bde_pkg::MulW-1:0]        b_i,
  output logic [2*bde_pkg::MulW-1:0]      prod_o
);
  import bde_pkg::*;

  logic [2*MulW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

### hdl/bde_div.sv
// ----------------------------------------------------------------------------
// bde_div - serial restoring divider
// one quotient bit per cycle, v^2 over the deceleration register
// ----------------------------------------------------------------------------
module bde_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bde_pkg::V2W-1:0]   dividend_i,
  input  logic [bde_pkg::DecW-1:0]  divisor_i,
  output logic                      busy_o,
  output logic [bde_pkg::V2W-1:0]   quotient_o
);
  import bde_pkg::*;

  localparam int unsigned CntW = $clog2(V2W);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [V2W-1:0]  num_q;
  logic [DecW-1:0] rem_q;
  logic [DecW-1:0] den_q;

  logic [DecW:0]   trial;
  logic            ge;
  logic [DecW:0]   diff;

  // a zero divisor gives an all-ones quotient, which the caller clips
  always_comb begin
    trial = {rem_q, num_q[V2W-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(V2W - 1);
      num_q  <= dividend_i;
      rem_q  <= '0;
      den_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DecW-1:0] : trial[DecW-1:0];
      num_q <= {num_q[V2W-2:0], ge};
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = num_q;

endmodule

### hdl/braking_distance_estimator.sv
// ----------------------------------------------------------------------------
// braking_distance_estimator - polynomial braking and emergency distance
// horner evaluation on one shared multiplier, serial divide for v^2 / decel
// ----------------------------------------------------------------------------
// usage
// - input stream: one velocity item per transfer, signed q8.16 m/s in tdata
// - output stream: braking distance and emergency distance in tdata,
//   saturation flag in tuser, one result item per input item
// - cfg_we_i / cfg_wdata_i write the emergency deceleration (unsigned q7.16 m/s^2);
//   write only while no item is in flight
// - an item occupies the block until its result goes to the output register;
//   each horner step runs on the single multiplier in the order low half,
//   high half, round, add; the divider runs alongside, and the sequencer
//   waits for it before loading the output register
// - s_axis_tready is high only while the sequencer is idle
// - the result sits in an output register; a new item is taken while it
//   waits, and the sequencer holds its last state until the register frees
// - reset clears the sequencer and output valid, deceleration to 9.81 m/s^2
// ----------------------------------------------------------------------------
module braking_distance_estimator #(
  parameter int unsigned TERM_COUNT    = bde_pkg::TermCountDefault,
  parameter int unsigned FRACTION_BITS = bde_pkg::FracBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [bde_pkg::VelW-1:0]     s_axis_tdata,   // [23:0] velocity
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [bde_pkg::DataOW-1:0]   m_axis_tdata,   // [31:0] brake distance,
                                                       // [62:32] emergency_distance
  output logic                         m_axis_tuser,   // [0] saturated
  input  logic                         cfg_we_i,
  input  logic [bde_pkg::DecW-1:0]     cfg_wdata_i
);
  import bde_pkg::*;

  // widths that follow from the fraction bits
  localparam int unsigned NormW = FRACTION_BITS + 5;   // |n| < 2^(F+4)
  localparam int unsigned CoefW = FRACTION_BITS + 12;  // |c| < 2^(F+11)
  localparam int unsigned IdxW  = $clog2(TERM_COUNT);
  localparam int unsigned DiffW = VelW + 2;

  // reciprocal scales, q.F
  localparam logic [MulW-1:0] RecipSlow =
    MulW'((((64'sd1 << FRACTION_BITS) * 64'sd10000) + ScaleSlowE4 / 2) / ScaleSlowE4);
  localparam logic [MulW-1:0] RecipFast =
    MulW'((((64'sd1 << FRACTION_BITS) * 64'sd10000) + ScaleFastE4 / 2) / ScaleFastE4);

  localparam logic signed [VelW-1:0]  SlowLim  = VelW'(SlowLimitQ16);
  localparam logic signed [DiffW-1:0] OffSlow  = DiffW'(OffSlowQ16);
  localparam logic signed [DiffW-1:0] OffFast  = DiffW'(OffFastQ16);
  localparam logic [63:0]             HalfF    = 64'd1 << (FRACTION_BITS - 1);
  localparam logic signed [63:0]      AccLimit = (64'sd1 <<< AccMagW) - 64'sd1;
  localparam logic signed [63:0]      TwoF     = 64'sd2 <<< FRACTION_BITS;

  // conversion of the final sum to q16.16
  localparam int unsigned ShDn   = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
  localparam int unsigned ShUp   = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
  localparam logic [63:0] HalfDn = (ShDn == 0) ? 64'd0 : (64'd1 << (ShDn - 1));
  localparam logic [63:0] UpLim  = (64'd1 << 31) >> ShUp;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NRM,   // diff * recip
    S_SQR,   // normalise, v * v, load top coefficient
    S_LOAD,  // start divider, low half of acc * n
    S_HLO,   // low half of acc * n
    S_HHI,   // high half of acc * n
    S_RND,   // round, clamp product
    S_ADD,   // add coefficient, clamp
    S_FIN,   // add 2.0
    S_CVT,   // to q16.16
    S_OUT    // wait for divider and output register
  } state_e;

  // fixed-point coefficient tables
  logic signed [CoefW-1:0] coef_slow [TERM_COUNT];
  logic signed [CoefW-1:0] coef_fast [TERM_COUNT];

  for (genvar g = 0; g < TERM_COUNT; g++) begin : g_coef
    assign coef_slow[g] = CoefW'(coef_fixed(SlowCoefE4[g], FRACTION_BITS));
    assign coef_fast[g] = CoefW'(coef_fixed(FastCoefE4[g], FRACTION_BITS));
  end

  // registers
  state_e                  state_q;
  logic                    slow_q;
  logic signed [DiffW-1:0] diff_q;
  logic [VelW-1:0]         vmag_q;
  logic [NormW-1:0]        norm_mag_q;
  logic                    norm_neg_q;
  logic [AccMagW-1:0]      acc_mag_q;
  logic                    acc_neg_q;
  logic [IdxW-1:0]         idx_q;
  logic [63:0]             plo_q;
  logic [AccMagW-1:0]      prr_q;
  logic signed [63:0]      fin_q;
  logic [63:0]             q16_mag_q;
  logic                    q16_neg_q;
  logic                    sat_q;
  logic [DecW-1:0]         dec_q;
  logic                    out_valid_q;
  logic [BrkW-1:0]         brk_q;
  logic [EmgW-1:0]         emg_q;
  logic                    osat_q;

  // shared units
  logic [MulW-1:0]   mul_a;
  logic [MulW-1:0]   mul_b;
  logic [2*MulW-1:0] prod;
  logic              div_busy;
  logic [V2W-1:0]    quot;

  bde_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  bde_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_LOAD),
    .dividend_i (prod[V2W-1:0]),
    .divisor_i  (dec_q),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  // datapath
  logic signed [VelW-1:0]  vel;
  logic                    slow_d;
  logic signed [DiffW-1:0] diff_d;
  logic [VelW-1:0]         vmag_d;
  logic [DiffW-1:0]        diff_mag;
  logic [63:0]             norm_sum;
  logic signed [CoefW-1:0] cinit;
  logic signed [CoefW-1:0] csel;
  logic [CoefW-1:0]        cinit_mag;
  logic [63:0]             plo_d;
  logic [2*MulW+31:0]      full;
  logic                    rnd_over;
  logic signed [63:0]      prod_s;
  logic signed [63:0]      sum;
  logic signed [63:0]      sum_neg;
  logic [AccMagW-1:0]      acc_mag_d;
  logic                    acc_neg_d;
  logic                    add_sat;
  logic signed [63:0]      acc_s;
  logic [63:0]             fin_mag;
  logic [63:0]             q16_d;
  logic                    cvt_sat;
  logic [BrkW-1:0]         brk_d;
  logic                    brk_sat;
  logic                    emg_over;
  logic                    out_free;
  logic                    out_load;

  always_comb begin
    vel    = $signed(s_axis_tdata);
    slow_d = vel < SlowLim;
    diff_d = DiffW'(vel) - (slow_d ? OffSlow : OffFast);
    vmag_d = vel[VelW-1] ? VelW'(-vel) : VelW'(vel);

    diff_mag = diff_q[DiffW-1] ? DiffW'(-diff_q) : DiffW'(diff_q);
    norm_sum = prod + 64'd32768;

    // operand selection for the shared multiplier
    unique case (state_q)
      S_NRM: begin
        mul_a = MulW'(diff_mag);
        mul_b = slow_q ? RecipSlow : RecipFast;
      end
      S_SQR: begin
        mul_a = MulW'(vmag_q);
        mul_b = MulW'(vmag_q);
      end
      S_LOAD, S_HLO: begin
        mul_a = acc_mag_q[MulW-1:0];
        mul_b = MulW'(norm_mag_q);
      end
      S_HHI: begin
        mul_a = MulW'(acc_mag_q[AccMagW-1:MulW]);
        mul_b = MulW'(norm_mag_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    cinit     = slow_q ? coef_slow[TERM_COUNT-1] : coef_fast[TERM_COUNT-1];
    cinit_mag = cinit[CoefW-1] ? CoefW'(-cinit) : CoefW'(cinit);
    csel      = slow_q ? coef_slow[idx_q] : coef_fast[idx_q];

    // rounding half folded into the low partial product
    plo_d    = prod + HalfF;
    full     = {prod, 32'd0} + {32'd0, plo_q};
    rnd_over = |full[2*MulW+31:AccMagW+FRACTION_BITS];

    // signed sum with coefficient, clamp to +-(2^61 - 1)
    prod_s  = (acc_neg_q ^ norm_neg_q) ? -$signed({3'd0, prr_q}) : $signed({3'd0, prr_q});
    sum     = prod_s + 64'(csel);
    sum_neg = -sum;
    add_sat = 1'b0;
    if (sum > AccLimit) begin
      acc_mag_d = AccMagW'(AccLimit);
      acc_neg_d = 1'b0;
      add_sat   = 1'b1;
    end else if (sum < -AccLimit) begin
      acc_mag_d = AccMagW'(AccLimit);
      acc_neg_d = 1'b1;
      add_sat   = 1'b1;
    end else begin
      acc_mag_d = sum[63] ? sum_neg[AccMagW-1:0] : sum[AccMagW-1:0];
      acc_neg_d = sum[63];
    end

    acc_s = acc_neg_q ? -$signed({3'd0, acc_mag_q}) : $signed({3'd0, acc_mag_q});

    // q.F to q16.16
    fin_mag = fin_q[63] ? 64'(-fin_q) : 64'(fin_q);
    cvt_sat = 1'b0;
    if (FRACTION_BITS >= 16) begin
      q16_d = (fin_mag + HalfDn) >> ShDn;
    end else if (fin_mag > UpLim) begin
      q16_d   = 64'd1 << 31;
      cvt_sat = 1'b1;
    end else begin
      q16_d = fin_mag << ShUp;
    end

    // clip to the signed 32-bit range
    brk_sat = 1'b0;
    if (!q16_neg_q && q16_mag_q > 64'h7FFF_FFFF) begin
      brk_d   = 32'h7FFF_FFFF;
      brk_sat = 1'b1;
    end else if (q16_neg_q && q16_mag_q > 64'h8000_0000) begin
      brk_d   = 32'h8000_0000;
      brk_sat = 1'b1;
    end else begin
      brk_d = q16_neg_q ? BrkW'(-q16_mag_q[BrkW-1:0]) : q16_mag_q[BrkW-1:0];
    end

    emg_over = |quot[V2W-1:EmgW];
    out_free = !out_valid_q || m_axis_tready;
    out_load = (state_q == S_OUT) && !div_busy && out_free;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slow_q      <= 1'b0;
      diff_q      <= '0;
      vmag_q      <= '0;
      norm_mag_q  <= '0;
      norm_neg_q  <= 1'b0;
      acc_mag_q   <= '0;
      acc_neg_q   <= 1'b0;
      idx_q       <= '0;
      plo_q       <= '0;
      prr_q       <= '0;
      fin_q       <= '0;
      q16_mag_q   <= '0;
      q16_neg_q   <= 1'b0;
      sat_q       <= 1'b0;
      dec_q       <= DecReset;
      out_valid_q <= 1'b0;
      brk_q       <= '0;
      emg_q       <= '0;
      osat_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dec_q <= cfg_wdata_i;
      end
      if (m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            slow_q  <= slow_d;
            diff_q  <= diff_d;
            vmag_q  <= vmag_d;
            state_q <= S_NRM;
          end
        end
        S_NRM: begin
          state_q <= S_SQR;
        end
        S_SQR: begin
          norm_mag_q <= norm_sum[NormW+15:16];
          norm_neg_q <= diff_q[DiffW-1];
          acc_mag_q  <= AccMagW'(cinit_mag);
          acc_neg_q  <= cinit[CoefW-1];
          idx_q      <= IdxW'(TERM_COUNT - 2);
          sat_q      <= 1'b0;
          state_q    <= S_LOAD;
        end
        S_LOAD, S_HLO: begin
          state_q <= S_HHI;
        end
        S_HHI: begin
          plo_q   <= plo_d;
          state_q <= S_RND;
        end
        S_RND: begin
          prr_q   <= rnd_over ? AccMagW'(AccLimit)
                              : full[AccMagW+FRACTION_BITS-1:FRACTION_BITS];
          sat_q   <= sat_q | rnd_over;
          state_q <= S_ADD;
        end
        S_ADD: begin
          acc_mag_q <= acc_mag_d;
          acc_neg_q <= acc_neg_d;
          sat_q     <= sat_q | add_sat;
          idx_q     <= idx_q - 1'b1;
          state_q   <= (idx_q == '0) ? S_FIN : S_HLO;
        end
        S_FIN: begin
          fin_q   <= acc_s + TwoF;
          state_q <= S_CVT;
        end
        S_CVT: begin
          q16_mag_q <= q16_d;
          q16_neg_q <= fin_q[63];
          sat_q     <= sat_q | cvt_sat;
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            brk_q       <= brk_d;
            emg_q       <= emg_over ? {EmgW{1'b1}} : quot[EmgW-1:0];
            osat_q      <= sat_q | brk_sat | emg_over;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, emg_q, brk_q};
  assign m_axis_tuser  = osat_q;

`ifndef SYNTHESIS
  // divider finished before the sequencer goes back to idle
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !div_busy)
    else $error("divider busy while idle");

  // divider free when a new division is launched
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> !div_busy)
    else $error("divider started while busy");

  // coefficient index stays inside the table during horner steps
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HLO || state_q == S_HHI || state_q == S_RND || state_q == S_ADD)
      |-> idx_q <= IdxW'(TERM_COUNT - 2))
    else $error("coefficient index out of range");

  // a result appears only from the output state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_OUT)
    else $error("result loaded outside output state");
`endif

endmodule

### sim/bde_checker.sv
// ----------------------------------------------------------------------------
// bde_checker - result predictor and scoreboard for the braking estimator
// predicts braking and emergency distance per accepted velocity item and
// compares each output item field by field, oldest expectation first
// ----------------------------------------------------------------------------
module bde_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [bde_pkg::VelW-1:0]     in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [bde_pkg::DataOW-1:0]   out_data_i,
  input  logic                         out_user_i,
  input  logic                         cfg_we_i,
  input  logic [bde_pkg::DecW-1:0]     cfg_wdata_i,
  output int                           pending_o,
  output int                           errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import bde_pkg::*;

  localparam int     Terms    = 16;
  localparam int     Frac     = 16;
  localparam longint AccLimit = (64'sd1 <<< 61) - 64'sd1;
  localparam longint SatHigh  = 64'sd2147483647;
  localparam longint SatLow   = -64'sd2147483648;
  localparam longint EmgMax   = 64'sh7FFF_FFFF;

  // offsets in q16.16, reciprocal scales in q.frac
  localparam longint OffsetSlow = (64'sd300079 * 64'sd65536 + 64'sd5000) / 64'sd10000;
  localparam longint OffsetFast = (64'sd414985 * 64'sd65536 + 64'sd5000) / 64'sd10000;
  localparam longint RecipSlow  =
    ((64'sd1 <<< Frac) * 64'sd10000 + 64'sd172325 / 2) / 64'sd172325;
  localparam longint RecipFast  =
    ((64'sd1 <<< Frac) * 64'sd10000 + 64'sd235436 / 2) / 64'sd235436;

  // coefficients in units of 1e-4, constant term first
  localparam int SlowE4 [Terms] = '{
    1363132, 1589403, 636093, -354894, -1492755, 1526967, 5025464, -2184689,
    -7795340, 957285, 6211013, 504598, -2450990, -545000, 380642, 123548};
  localparam int FastE4 [Terms] = '{
    2586000, 2992000, 1152000, -1047000, -2609000, 4885000, 9408000, -8085000,
    -15519000, 5517000, 13157000, -614000, -5514000, -845000, 907000, 262000};

  typedef struct packed {
    logic [VelW-1:0]        velocity;
    logic signed [BrkW-1:0] braking;
    logic [EmgW-1:0]        emergency;
    logic                   saturated;
  } distance_t;

  distance_t       expected_distances [$];
  distance_t       want;
  logic [DecW-1:0] decel_copy;

  function automatic distance_t predict_distances(input logic [VelW-1:0] vel_raw,
                                                  input logic [DecW-1:0] decel);
    distance_t            r;
    longint               v, offset, recip, norm, acc, coef, prod_s;
    longint unsigned      mag, mag_n, speed_sq, quot;
    logic [127:0]         prod;
    bit                   slow, sat;
    int                   e4;
    v      = longint'(signed'(vel_raw));
    sat    = 1'b0;
    slow   = v < SlowLimitQ16;
    offset = slow ? OffsetSlow : OffsetFast;
    recip  = slow ? RecipSlow : RecipFast;
    // normalised velocity, rounded half away from zero
    prod_s = (v - offset) * recip;
    mag    = (prod_s < 0) ? -prod_s : prod_s;
    mag    = (mag + 64'd32768) >> 16;
    norm   = (prod_s < 0) ? -longint'(mag) : longint'(mag);
    mag_n  = (norm < 0) ? -norm : norm;
    acc    = 0;
    // horner from the top term down
    for (int i = Terms - 1; i >= 0; i--) begin
      e4   = slow ? SlowE4[i] : FastE4[i];
      mag  = (e4 < 0) ? longint'(-e4) : longint'(e4);
      mag  = ((mag << Frac) + 64'd5000) / 64'd10000;
      coef = (e4 < 0) ? -longint'(mag) : longint'(mag);
      if (i == Terms - 1) begin
        acc = coef;
      end else begin
        mag  = (acc < 0) ? -acc : acc;
        prod = {64'd0, mag} * {64'd0, mag_n};
        prod = (prod + (128'd1 << (Frac - 1))) >> Frac;
        if (prod > 128'(AccLimit)) begin
          sat  = 1'b1;
          prod = 128'(AccLimit);
        end
        prod_s = longint'(prod[63:0]);
        if ((acc < 0) != (norm < 0)) prod_s = -prod_s;
        acc = prod_s + coef;
        if (acc > AccLimit) begin
          sat = 1'b1;
          acc = AccLimit;
        end else if (acc < -AccLimit) begin
          sat = 1'b1;
          acc = -AccLimit;
        end
      end
    end
    acc = acc + (64'sd2 <<< Frac);
    if (acc > SatHigh) begin
      sat = 1'b1;
      acc = SatHigh;
    end else if (acc < SatLow) begin
      sat = 1'b1;
      acc = SatLow;
    end
    // emergency distance, v^2 over deceleration
    mag      = (v < 0) ? -v : v;
    speed_sq = mag * mag;
    if (decel == '0) begin
      quot = EmgMax;
      sat  = 1'b1;
    end else begin
      quot = speed_sq / longint'(decel);
      if (quot > EmgMax) begin
        quot = EmgMax;
        sat  = 1'b1;
      end
    end
    r.velocity  = vel_raw;
    r.braking   = acc[BrkW-1:0];
    r.emergency = quot[EmgW-1:0];
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [VelW-1:0] vel,
                                 input longint got, input longint exp_val);
    $display("mismatch %s: velocity %h got %0d expected %0d", field, vel, got, exp_val);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decel_copy = DecReset;
      expected_distances.delete();
      errors_o  = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_distances.size() == 0) begin
          report_mismatch("unexpected result", '0, longint'(out_data_i[BrkW-1:0]), 0);
        end else begin
          want = expected_distances.pop_front();
          if (out_data_i[BrkW-1:0] != want.braking)
            report_mismatch("brake_dist", want.velocity,
                            longint'(signed'(out_data_i[BrkW-1:0])), longint'(want.braking));
          if (out_data_i[BrkW +: EmgW] != want.emergency)
            report_mismatch("emergency_distance", want.velocity,
                            longint'(out_data_i[BrkW +: EmgW]), longint'(want.emergency));
          if (out_user_i != want.saturated)
            report_mismatch("saturated", want.velocity,
                            longint'(out_user_i), longint'(want.saturated));
        end
      end
      if (in_valid_i && in_ready_i)
        expected_distances.push_back(predict_distances(in_data_i, decel_copy));
      if (cfg_we_i) decel_copy = cfg_wdata_i;
      pending_o <= expected_distances.size();
    end
  end

endmodule

### sim/tb_braking_distance_estimator.sv
// ----------------------------------------------------------------------------
// tb_braking_distance_estimator - stimulus and verdict for the estimator
// drives corner and random velocities through several deceleration settings
// with random idling on both streams; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_braking_distance_estimator;
  timeunit 1ns;
  timeprecision 1ps;

  import bde_pkg::*;

  localparam int unsigned PhaseCount     = 8;
  localparam int unsigned RandomPerPhase = 75;
  localparam int unsigned MaxGap         = 80;   // longer than one item's work
  localparam int unsigned IdlePercent    = 19;
  localparam int unsigned DrainCycles    = 70;   // about one item's latency

  // extremes, the slow/fast boundary, the two offsets and bit patterns
  localparam logic [VelW-1:0] CornerVelocities [18] = '{
    24'h800000,  // most negative
    24'h7FFFFF,  // most positive
    24'h000000,
    24'h000001,
    24'hFFFFFF,  // minus one lsb
    24'd3276799, // just below 50 m/s
    24'd3276800, // exactly 50 m/s, fast set
    24'd3276801,
    24'd1966598, // slow offset, normalised velocity zero
    24'd2719646, // fast offset
    24'd65536,
    24'd655360,
    -24'sd655360,
    24'd6553600,
    -24'sd6553600,
    24'h555555,
    24'hAAAAAA,
    24'h810000
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [VelW-1:0]     s_axis_tdata = '0;    // [23:0] velocity
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DataOW-1:0]   m_axis_tdata;         // [31:0] braking, [62:32] emergency
  logic                m_axis_tuser;         // [0] saturated
  logic                cfg_we_i = 1'b0;
  logic [DecW-1:0]     cfg_wdata_i = '0;
  int                  pending;
  int                  errors;
  bit                  no_idle = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  braking_distance_estimator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  bde_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_user_i  (m_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // receiver back-pressure, off during the steady phase
  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IdlePercent);
  end

  // mix of full-range, realistic, boundary and extreme velocities
  function automatic logic [VelW-1:0] random_velocity();
    int unsigned pick;
    int          delta;
    pick  = $urandom_range(0, 99);
    delta = int'($urandom_range(0, 512)) - 256;
    if (pick < 40) return VelW'($urandom());
    if (pick < 60) return VelW'($urandom_range(0, 24'h7FFFFF));
    if (pick < 70) return VelW'(-int'($urandom_range(0, 655360)));
    if (pick < 85) return VelW'(SlowLimitQ16 + delta);
    if (pick < 93) return 24'h800000 + VelW'($urandom_range(0, 255));
    return 24'h7FFFFF - VelW'($urandom_range(0, 255));
  endfunction

  // present one item, keep valid high unless a gap is taken
  task automatic push_velocity(input logic [VelW-1:0] vel);
    if (!no_idle && $urandom_range(0, 99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, MaxGap)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= vel;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop sending and wait until every expected item has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic load_deceleration(input logic [DecW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      // phase 0 runs on the reset deceleration
      if (phase > 0) begin
        drain_results();
        case (phase)
          1: load_deceleration('0);                 // zero divisor
          2: load_deceleration(DecW'(1));           // quotient overflows
          3: load_deceleration(DecW'(6554));        // lowest useful value
          4: load_deceleration(DecW'(6553600));     // 100 m/s^2
          5: load_deceleration('1);                 // all ones
          6: load_deceleration(DecW'($urandom_range(6554, 6553600)));
          default: load_deceleration(DecW'($urandom()));
        endcase
      end
      // one long stretch with no idling on either side
      no_idle = (phase == 3);
      if (phase == 0 || phase == 1) begin
        foreach (CornerVelocities[k]) push_velocity(CornerVelocities[k]);
      end
      repeat (RandomPerPhase) push_velocity(random_velocity());
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // several times the slowest legal run
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
hdl/bde_pkg.sv
hdl/bde_mul.sv
hdl/bde_div.sv
hdl/braking_distance_estimator.sv
sim/bde_checker.sv
sim/tb_braking_distance_estimator.sv
